>>> design/assert_macros.svh
// Assertion macros used by the checker module of this block.
// Relies on clk and arst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is applied.
`define CMA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must never be seen outside reset.
`define CMA_ASSERT_NEVER(lbl, cond, msg) \
	`CMA_ASSERT(lbl, !(cond), msg)

`endif

>>> design/cma_pkg.sv
// Package for the cube map texel addressing block: defaults, face codes,
// output widths and the queue status type. No dependencies.
`timescale 1ns / 1ps

package cma_pkg;

	localparam int DEF_MAX_FACE_SIZE  = 1024;
	localparam int DEF_COMPONENT_BITS = 16;
	localparam int MIN_FACE_SIZE      = 8;

	localparam int CFG_W   = 11;
	localparam int FACE_W  = 3;
	localparam int COORD_W = 10;
	localparam int IDX_W   = 23;

	localparam logic [CFG_W-1:0] FACE_SIZE_RESET = 11'd32;

	localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
	localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
	localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

	typedef struct packed {
		logic full;
		logic empty;
	} cma_qstat_t;

endpackage

>>> design/cma_front.sv
// Front end: picks the major axis and face, forms the face offsets and
// clamps the face size. Depends on cma_pkg.
`timescale 1ns / 1ps

module cma_front import cma_pkg::*; #(
	parameter int MaxFaceSize = DEF_MAX_FACE_SIZE,
	parameter int CompBits    = DEF_COMPONENT_BITS,
	localparam int SW = $clog2(MaxFaceSize + 1),
	localparam int OW = CompBits + 1,
	localparam int EW = FACE_W + 1 + SW + 2 * OW + CompBits
) (
	input  logic signed [CompBits-1:0] dir_x,
	input  logic signed [CompBits-1:0] dir_y,
	input  logic signed [CompBits-1:0] dir_z,
	input  logic        [CFG_W-1:0]    edge_cfg,
	output logic        [EW-1:0]       entry
);

	logic        [CompBits-1:0] ax, ay, az, ma;
	logic signed [OW-1:0]       xs, ys, zs, sc, tc, ma_e;
	logic        [OW-1:0]       usc, utc;
	logic        [FACE_W-1:0]   face;
	logic                       zero;
	logic        [SW-1:0]       size;

	always_comb begin
		ax = dir_x[CompBits-1] ? CompBits'(-dir_x) : CompBits'(dir_x);
		ay = dir_y[CompBits-1] ? CompBits'(-dir_y) : CompBits'(dir_y);
		az = dir_z[CompBits-1] ? CompBits'(-dir_z) : CompBits'(dir_z);
		xs = OW'(dir_x);
		ys = OW'(dir_y);
		zs = OW'(dir_z);

		// y wins ties, then z
		if (ay >= ax && ay >= az) begin
			ma = ay;
			sc = xs;
			if (dir_y > 0) begin
				face = FACE_POS_Y;
				tc   = zs;
			end else begin
				face = FACE_NEG_Y;
				tc   = -zs;
			end
		end else if (az >= ax && az >= ay) begin
			ma = az;
			tc = -ys;
			if (dir_z > 0) begin
				face = FACE_POS_Z;
				sc   = xs;
			end else begin
				face = FACE_NEG_Z;
				sc   = -xs;
			end
		end else begin
			ma = ax;
			tc = -ys;
			if (dir_x > 0) begin
				face = FACE_POS_X;
				sc   = -zs;
			end else begin
				face = FACE_NEG_X;
				sc   = zs;
			end
		end

		// zero vector lands on the center of +y
		zero = (ma == '0);
		if (zero) begin
			face = FACE_POS_Y;
		end

		ma_e = signed'({1'b0, ma});
		usc  = sc + ma_e;
		utc  = tc + ma_e;

		if (32'(edge_cfg) < 32'(MIN_FACE_SIZE)) begin
			size = SW'(MIN_FACE_SIZE);
		end else if (32'(edge_cfg) > 32'(MaxFaceSize)) begin
			size = SW'(MaxFaceSize);
		end else begin
			size = SW'(edge_cfg);
		end

		entry = {face, zero, size, usc, utc, ma};
	end

endmodule

>>> design/cma_queue.sv
// Two-entry queue between front and back end, payload as a flat vector.
// Depends on cma_pkg for the status type.
`timescale 1ns / 1ps

module cma_queue import cma_pkg::*; #(
	parameter int Width = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] wdata,
	input  logic             pop,
	output logic [Width-1:0] rdata,
	output cma_qstat_t       stat
);

	logic [Width-1:0] mem_q [0:1];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             do_push, do_pop;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

>>> design/cma_back.sv
// Back end: scales the offsets, runs two restoring dividers one quotient
// bit per stage, clamps and forms the linear index. Depends on cma_pkg.
`timescale 1ns / 1ps

module cma_back import cma_pkg::*; #(
	parameter int MaxFaceSize = DEF_MAX_FACE_SIZE,
	parameter int CompBits    = DEF_COMPONENT_BITS,
	localparam int SW = $clog2(MaxFaceSize + 1),
	localparam int OW = CompBits + 1,
	localparam int EW = FACE_W + 1 + SW + 2 * OW + CompBits
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [EW-1:0]        entry,
	output logic                 done,
	output logic [FACE_W-1:0]    face,
	output logic [COORD_W-1:0]   texel_col,
	output logic [COORD_W-1:0]   texel_row,
	output logic [IDX_W-1:0]     texel_index
);

	localparam int QW = SW;
	localparam int NW = OW + SW;
	localparam int FW = FACE_W + SW;
	localparam int IW = FACE_W + 2 * SW;

	logic [FACE_W-1:0]   e_face;
	logic                e_zero;
	logic [SW-1:0]       e_size;
	logic [OW-1:0]       e_usc, e_utc;
	logic [CompBits-1:0] e_ma;

	assign {e_face, e_zero, e_size, e_usc, e_utc, e_ma} = entry;

	// divider pipe, element 0 is the scaling stage
	logic                vld_s  [0:QW];
	logic [FACE_W-1:0]   face_s [0:QW];
	logic                zero_s [0:QW];
	logic [SW-1:0]       size_s [0:QW];
	logic [OW-1:0]       den_s  [0:QW];
	logic [NW-1:0]       crem_s [0:QW];
	logic [NW-1:0]       rrem_s [0:QW];
	logic [QW-1:0]       cq_s   [0:QW];
	logic [QW-1:0]       rq_s   [0:QW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		face_s[0] <= e_face;
		zero_s[0] <= e_zero;
		size_s[0] <= e_size;
		den_s[0]  <= {e_ma, 1'b0};
		crem_s[0] <= NW'(e_usc) * NW'(e_size);
		rrem_s[0] <= NW'(e_utc) * NW'(e_size);
		cq_s[0]   <= '0;
		rq_s[0]   <= '0;
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		logic [NW:0] sh;
		logic        c_ge, r_ge;

		always_comb begin
			sh   = (NW + 1)'(den_s[k]) << (QW - 1 - k);
			c_ge = ({1'b0, crem_s[k]} >= sh);
			r_ge = ({1'b0, rrem_s[k]} >= sh);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			face_s[k+1] <= face_s[k];
			zero_s[k+1] <= zero_s[k];
			size_s[k+1] <= size_s[k];
			den_s[k+1]  <= den_s[k];
			crem_s[k+1] <= c_ge ? NW'({1'b0, crem_s[k]} - sh) : crem_s[k];
			rrem_s[k+1] <= r_ge ? NW'({1'b0, rrem_s[k]} - sh) : rrem_s[k];
			cq_s[k+1]   <= {cq_s[k][QW-2:0], c_ge};
			rq_s[k+1]   <= {rq_s[k][QW-2:0], r_ge};
		end
	end

	// clamp and both halves of the index
	logic [SW-1:0] col_c, row_c, size_d;
	logic          vld_s2, vld_s3;
	logic [FACE_W-1:0] face_s2, face_s3;
	logic [SW-1:0] col_s2, row_s2, size_s2, col_s3, row_s3;
	logic [FW-1:0] fr_s2;
	logic [IW-1:0] idx_s3;

	always_comb begin
		size_d = size_s[QW];
		if (zero_s[QW]) begin
			col_c = size_d >> 1;
			row_c = size_d >> 1;
		end else begin
			col_c = (cq_s[QW] >= size_d) ? size_d - SW'(1) : cq_s[QW];
			row_c = (rq_s[QW] >= size_d) ? size_d - SW'(1) : rq_s[QW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s[QW];
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		face_s2 <= face_s[QW];
		col_s2  <= col_c;
		row_s2  <= row_c;
		size_s2 <= size_d;
		fr_s2   <= FW'(face_s[QW]) * FW'(size_d) + FW'(row_c);
		face_s3 <= face_s2;
		col_s3  <= col_s2;
		row_s3  <= row_s2;
		idx_s3  <= IW'(fr_s2) * IW'(size_s2) + IW'(col_s2);
	end

	assign done        = vld_s3;
	assign face        = face_s3;
	assign texel_col   = COORD_W'(col_s3);
	assign texel_row   = COORD_W'(row_s3);
	assign texel_index = IDX_W'(idx_s3);

endmodule

>>> design/cube_map_texel_address.sv
// Top level of the cube map texel addressing block.
// Depends on cma_pkg, cma_front, cma_queue and cma_back.
//
//   channel   signals                                      handshake
//   -------   ------------------------------------------   ------------------------
//   input     dir_x, dir_y, dir_z                          start && !busy
//   result    face, texel_col, texel_row, texel_index      done, one cycle, no stall
//   config    cfg_wdata (face edge length)                 cfg_we
//
// One item per clock is accepted and one result per clock is given.
// The queue write happens at the accepting edge itself; from the queue head an
// item passes the scaling stage, the divider, one quotient bit per pipeline
// stage, and the two index stages before its done cycle.
// Reset clears the queue, all stage valids and sets the face edge register to 32.
// The receiver cannot stall; the back end drains the queue every cycle, so the
// queue never holds more than one item and busy stays low.
`timescale 1ns / 1ps

module cube_map_texel_address import cma_pkg::*; #(
	parameter int MaxFaceSize = DEF_MAX_FACE_SIZE,
	parameter int CompBits    = DEF_COMPONENT_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [CompBits-1:0] dir_x,
	input  logic signed [CompBits-1:0] dir_y,
	input  logic signed [CompBits-1:0] dir_z,
	input  logic                       cfg_we,
	input  logic        [CFG_W-1:0]    cfg_wdata,
	output logic                       done,
	output logic        [FACE_W-1:0]   face,
	output logic        [COORD_W-1:0]  texel_col,
	output logic        [COORD_W-1:0]  texel_row,
	output logic        [IDX_W-1:0]    texel_index
);

	localparam int SW = $clog2(MaxFaceSize + 1);
	localparam int OW = CompBits + 1;
	localparam int EW = FACE_W + 1 + SW + 2 * OW + CompBits;

	logic [CFG_W-1:0] edge_cfg_q;
	logic [EW-1:0]    front_entry, queue_head;
	cma_qstat_t       qstat;
	logic             push;

	// face edge register, raw value; clamping happens in the front end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_cfg_q <= FACE_SIZE_RESET;
		end else if (cfg_we) begin
			edge_cfg_q <= cfg_wdata;
		end
	end

	// accept whenever the queue has room
	assign busy = qstat.full;
	assign push = start && !busy;

	cma_front #(
		.MaxFaceSize (MaxFaceSize),
		.CompBits    (CompBits)
	) u_front (
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z),
		.edge_cfg (edge_cfg_q),
		.entry    (front_entry)
	);

	// queue parts front and back; the back end drains the head every cycle
	cma_queue #(
		.Width (EW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_entry),
		.pop    (!qstat.empty),
		.rdata  (queue_head),
		.stat   (qstat)
	);

	cma_back #(
		.MaxFaceSize (MaxFaceSize),
		.CompBits    (CompBits)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (!qstat.empty),
		.entry       (queue_head),
		.done        (done),
		.face        (face),
		.texel_col   (texel_col),
		.texel_row   (texel_row),
		.texel_index (texel_index)
	);

endmodule

>>> design/cma_checker.sv
// Port-level checks for cube_map_texel_address, bound to the top level.
// Depends on cma_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cma_checker import cma_pkg::*; #(
	parameter int MaxFaceSize = DEF_MAX_FACE_SIZE,
	parameter int CompBits    = DEF_COMPONENT_BITS
) (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic [CompBits-1:0] dir_x,
	input logic [CompBits-1:0] dir_y,
	input logic [CompBits-1:0] dir_z,
	input logic                done,
	input logic [FACE_W-1:0]   face,
	input logic [COORD_W-1:0]  texel_col,
	input logic [COORD_W-1:0]  texel_row
);

	localparam int Lat = $clog2(MaxFaceSize + 1) + 4;

	logic take, zero_in, at_mid;

	assign take    = start && !busy;
	assign zero_in = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
	assign at_mid  = (face == FACE_POS_Y) && (texel_col == texel_row);

	// back end never stalls, so the queue cannot fill
	`CMA_ASSERT_NEVER(a_no_busy, busy, "queue filled up")

	`CMA_ASSERT(a_fixed_latency, take |-> ##Lat done, "result missing")

	`CMA_ASSERT(a_no_spurious, done |-> $past(take, Lat), "result without item")

	`CMA_ASSERT(a_zero_vec, (take && zero_in) |-> ##Lat at_mid, "zero vector off +y center")

endmodule

bind cube_map_texel_address cma_checker #(
	.MaxFaceSize (MaxFaceSize),
	.CompBits    (CompBits)
) u_cma_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.dir_x     (dir_x),
	.dir_y     (dir_y),
	.dir_z     (dir_z),
	.done      (done),
	.face      (face),
	.texel_col (texel_col),
	.texel_row (texel_row)
);
